FILE: rtl/mlbm_pkg.sv
// ----------------------------------------------------------------------------
// mlbm_pkg
// Shared types and constants for the modulated light-barrier monitor:
// word layouts, command kinds, register map and register reset values.
// ----------------------------------------------------------------------------
package mlbm_pkg;

   // field widths fixed by the interface
   localparam int KIND_W       = 2;
   localparam int BRIGHT_W     = 12;
   localparam int TIMEOUT_W    = 16;
   localparam int INTERVAL_W   = 8;
   localparam int DIFF_W       = 12;
   localparam int RATIO_W      = 12;
   localparam int FAIL_W       = 8;
   localparam int PICKS_W      = 3;
   localparam int TOTAL_W      = 16;
   localparam int STATUS_W     = 2;

   // default receiver sample width
   localparam int SAMPLE_BITS_DEF = 12;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INTERVAL = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_DIFF = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RATIO    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_FAIL = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_INIT_PKS = 3'd5;

   // register reset values
   localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST  = 16'd50000;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 8'd5;
   localparam logic [DIFF_W-1:0]     MIN_DIFF_RST = 12'd5;
   localparam logic [RATIO_W-1:0]    RATIO_RST    = 12'd1050;
   localparam logic [FAIL_W-1:0]     MAX_FAIL_RST = 8'd3;
   localparam logic [PICKS_W-1:0]    INIT_PKS_RST = 3'd5;

   // command kinds
   localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_START = 2'd1;
   localparam logic [KIND_W-1:0] KIND_STOP  = 2'd2;

   // start status codes
   localparam logic [STATUS_W-1:0] STAT_IDLE    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_PICKING = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_STARTED = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_FAILED  = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [BRIGHT_W-1:0] brightness;
   } req_word_type;

   typedef struct packed {
      logic                emitter_on;
      logic                measuring;
      logic [STATUS_W-1:0] start_status;
      logic                safe;
      logic [FAIL_W-1:0]   failures_in_row;
      logic [TOTAL_W-1:0]  total_picks;
   } rsp_word_type;

endpackage

FILE: rtl/modulated_light_barrier_monitor.sv
// ----------------------------------------------------------------------------
// modulated_light_barrier_monitor
// Drives a light-barrier emitter through a start-up majority check and a
// running phase of alternating off/on picks, judging receiver samples.
// ----------------------------------------------------------------------------
//
//  channel | ports                             | direction | word
//  --------+-----------------------------------+-----------+----------------
//  request | req_valid / req_ready / req_data  | in        | req_word_type
//  result  | rsp_valid / rsp_ready / rsp_data  | out       | rsp_word_type
//  csr     | csr_valid / csr_ready / csr_index | in        | index + data
//          | csr_data                          |           |
//
// One word per cycle sustained unless the result side stalls; the result is
// registered: the accepted request goes into the input register, then the
// state update writes the result register. The pick judgment (two small
// products and a compare) sits in the one stage between the two.
// Reset is synchronous, clears all control state and reloads the register
// defaults.
// A stalled result holds the result register and backs up through the input
// register; csr writes are always taken.
// ----------------------------------------------------------------------------
module modulated_light_barrier_monitor
   import mlbm_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_word_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int SW     = SAMPLE_BITS;
   localparam int EXT_W  = (SW > BRIGHT_W) ? SW : BRIGHT_W;
   localparam int DCMP_W = (SW > DIFF_W) ? SW : DIFF_W;
   localparam int PROD_W = SW + RATIO_W;

   localparam logic [2:0] PH_IDLE     = 3'd0;
   localparam logic [2:0] PH_INIT_ON  = 3'd1;
   localparam logic [2:0] PH_INIT_GAP = 3'd2;
   localparam logic [2:0] PH_RUN_OFF  = 3'd3;
   localparam logic [2:0] PH_RUN_ON   = 3'd4;

   localparam logic [INTERVAL_W-1:0] ITMR_MAX  = '1;
   localparam logic [TIMEOUT_W-1:0]  RTMR_MAX  = '1;
   localparam logic [FAIL_W-1:0]     FAIL_MAX  = '1;
   localparam logic [TOTAL_W-1:0]    TOTAL_MAX = '1;

   // configuration registers
   logic [TIMEOUT_W-1:0]  timeout_ff;
   logic [INTERVAL_W-1:0] interval_ff;
   logic [DIFF_W-1:0]     min_diff_ff;
   logic [RATIO_W-1:0]    ratio_ff;
   logic [FAIL_W-1:0]     max_fail_ff;
   logic [PICKS_W-1:0]    init_picks_ff;

   // pipeline registers
   logic         in_valid_ff;
   req_word_type in_word_ff;
   logic         rsp_valid_ff;
   rsp_word_type rsp_data_ff, rsp_data_in;

   // monitor state
   logic [2:0]            phase_ff, phase_in;
   logic                  emitter_ff, emitter_in;
   logic [TIMEOUT_W-1:0]  run_timer_ff, run_timer_in;
   logic [INTERVAL_W-1:0] itimer_ff, itimer_in;
   logic [SW-1:0]         off_sample_ff, off_sample_in;
   logic [PICKS_W-1:0]    pick_index_ff, pick_index_in;
   logic [PICKS_W-1:0]    pass_count_ff, pass_count_in;
   logic [FAIL_W-1:0]     fail_count_ff, fail_count_in;
   logic [TOTAL_W-1:0]    pick_total_ff, pick_total_in;
   logic [STATUS_W-1:0]   status_ff, status_in;

   logic advance;
   logic [EXT_W-1:0]      bright_ext;
   logic [SW-1:0]         smp;
   logic [SW-1:0]         diff;
   logic [PROD_W-1:0]     prod_on, prod_off;
   logic                  pick_pass;
   logic [INTERVAL_W-1:0] itimer_inc;
   logic                  itimer_done;
   logic                  timed_out;
   logic [PICKS_W:0]      pass_twice;

   // handshake: the input stage moves when the result slot frees up
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff    <= TIMEOUT_RST;
         interval_ff   <= INTERVAL_RST;
         min_diff_ff   <= MIN_DIFF_RST;
         ratio_ff      <= RATIO_RST;
         max_fail_ff   <= MAX_FAIL_RST;
         init_picks_ff <= INIT_PKS_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_TIMEOUT:  timeout_ff    <= csr_data[TIMEOUT_W-1:0];
            REG_INTERVAL: interval_ff   <= csr_data[INTERVAL_W-1:0];
            REG_MIN_DIFF: min_diff_ff   <= csr_data[DIFF_W-1:0];
            REG_RATIO:    ratio_ff      <= csr_data[RATIO_W-1:0];
            REG_MAX_FAIL: max_fail_ff   <= csr_data[FAIL_W-1:0];
            REG_INIT_PKS: init_picks_ff <= csr_data[PICKS_W-1:0];
            default: ;
         endcase
      end
   end

   // sample taken to the configured width
   assign bright_ext = EXT_W'(in_word_ff.brightness);
   assign smp        = bright_ext[SW-1:0];

   // pick judgment against the stored off sample
   assign diff     = smp - off_sample_ff;
   assign prod_on  = PROD_W'(smp) * PROD_W'(1000);
   assign prod_off = PROD_W'(off_sample_ff) * PROD_W'(ratio_ff);
   assign pick_pass = ((off_sample_ff == '0) && (smp != '0)) ||
                      ((smp > off_sample_ff) &&
                       (DCMP_W'(diff) >= DCMP_W'(min_diff_ff)) &&
                       (prod_on >= prod_off));

   // timers
   assign itimer_inc  = (itimer_ff != ITMR_MAX) ? itimer_ff + 1'b1 : itimer_ff;
   assign itimer_done = itimer_inc >= interval_ff;
   assign timed_out   = run_timer_ff >= timeout_ff;
   assign pass_twice  = {pass_count_ff, 1'b0};

   // next state for one word
   always_comb begin
      phase_in      = phase_ff;
      emitter_in    = emitter_ff;
      run_timer_in  = run_timer_ff;
      itimer_in     = itimer_ff;
      off_sample_in = off_sample_ff;
      pick_index_in = pick_index_ff;
      pass_count_in = pass_count_ff;
      fail_count_in = fail_count_ff;
      pick_total_in = pick_total_ff;
      status_in     = status_ff;

      case (in_word_ff.kind)
         KIND_START: begin
            run_timer_in  = '0;
            itimer_in     = '0;
            fail_count_in = '0;
            pick_index_in = '0;
            pass_count_in = '0;
            if (init_picks_ff == '0) begin
               phase_in   = PH_IDLE;
               emitter_in = 1'b0;
               status_in  = STAT_FAILED;
            end else begin
               off_sample_in = smp;
               emitter_in    = 1'b1;
               phase_in      = PH_INIT_ON;
               status_in     = STAT_PICKING;
            end
         end
         KIND_STOP: begin
            phase_in      = PH_IDLE;
            emitter_in    = 1'b0;
            pick_total_in = '0;
         end
         KIND_TICK: begin
            if (phase_ff != PH_IDLE) begin
               if (run_timer_ff != RTMR_MAX)
                  run_timer_in = run_timer_ff + 1'b1;
               unique case (phase_ff)
                  // start-up pick, emitter on
                  PH_INIT_ON: begin
                     itimer_in = itimer_inc;
                     if (itimer_done) begin
                        if (pick_pass)
                           pass_count_in = pass_count_ff + 1'b1;
                        pick_index_in = pick_index_ff + 1'b1;
                        emitter_in    = 1'b0;
                        itimer_in     = '0;
                        phase_in      = PH_INIT_GAP;
                     end
                  end
                  // start-up gap, emitter off
                  PH_INIT_GAP: begin
                     itimer_in = itimer_inc;
                     if (itimer_done) begin
                        if (pick_index_ff >= init_picks_ff) begin
                           emitter_in = 1'b0;
                           if (pass_twice > {1'b0, pick_index_ff}) begin
                              status_in = STAT_STARTED;
                              phase_in  = PH_RUN_OFF;
                              itimer_in = ITMR_MAX;
                           end else begin
                              status_in = STAT_FAILED;
                              phase_in  = PH_IDLE;
                           end
                        end else begin
                           off_sample_in = smp;
                           emitter_in    = 1'b1;
                           itimer_in     = '0;
                           phase_in      = PH_INIT_ON;
                        end
                     end
                  end
                  // running phase
                  default: begin
                     if (timed_out) begin
                        emitter_in = 1'b0;
                        phase_in   = PH_IDLE;
                     end else if (itimer_ff < interval_ff) begin
                        itimer_in = itimer_ff + 1'b1;
                     end else if (phase_ff == PH_RUN_OFF) begin
                        off_sample_in = smp;
                        emitter_in    = 1'b1;
                        itimer_in     = '0;
                        phase_in      = PH_RUN_ON;
                     end else begin
                        emitter_in = 1'b0;
                        itimer_in  = '0;
                        phase_in   = PH_RUN_OFF;
                        if (pick_total_ff != TOTAL_MAX)
                           pick_total_in = pick_total_ff + 1'b1;
                        if (pick_pass)
                           fail_count_in = '0;
                        else if (fail_count_ff != FAIL_MAX)
                           fail_count_in = fail_count_ff + 1'b1;
                     end
                  end
               endcase
            end
         end
         default: ;
      endcase

      // result word shows the state after this step
      rsp_data_in.emitter_on      = emitter_in;
      rsp_data_in.measuring       = (phase_in == PH_RUN_OFF) || (phase_in == PH_RUN_ON);
      rsp_data_in.start_status    = status_in;
      rsp_data_in.safe            = fail_count_in <= max_fail_ff;
      rsp_data_in.failures_in_row = fail_count_in;
      rsp_data_in.total_picks     = pick_total_in;
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid)
         in_word_ff <= req_data;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance)
         rsp_data_ff <= rsp_data_in;
   end

   // monitor state update
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         emitter_ff    <= 1'b0;
         run_timer_ff  <= '0;
         itimer_ff     <= '0;
         off_sample_ff <= '0;
         pick_index_ff <= '0;
         pass_count_ff <= '0;
         fail_count_ff <= '0;
         pick_total_ff <= '0;
         status_ff     <= STAT_IDLE;
      end else if (advance) begin
         phase_ff      <= phase_in;
         emitter_ff    <= emitter_in;
         run_timer_ff  <= run_timer_in;
         itimer_ff     <= itimer_in;
         off_sample_ff <= off_sample_in;
         pick_index_ff <= pick_index_in;
         pass_count_ff <= pass_count_in;
         fail_count_ff <= fail_count_in;
         pick_total_ff <= pick_total_in;
         status_ff     <= status_in;
      end
   end

endmodule

FILE: tb/tb_modulated_light_barrier_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modulated_light_barrier_monitor
// Self-checking bench for the light-barrier monitor. A cycle model of the
// start-up picks and the running phase predicts the status word for every
// request word; a checker compares each result field by field. Directed
// tests cover the special cases, then random sessions with shaped light
// samples run under changing register settings and random stalls.
// ----------------------------------------------------------------------------
module tb_modulated_light_barrier_monitor;
   import mlbm_pkg::*;

   // codes the package leaves unnamed
   localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED  = 3'd7;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_INIT_ON,
      PH_INIT_GAP,
      PH_RUN_OFF,
      PH_RUN_ON
   } barrier_phase_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_word_type          req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_word_type          rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // register copies
   logic [TIMEOUT_W-1:0]  cfg_timeout;
   logic [INTERVAL_W-1:0] cfg_interval;
   logic [DIFF_W-1:0]     cfg_min_diff;
   logic [RATIO_W-1:0]    cfg_ratio;
   logic [FAIL_W-1:0]     cfg_max_fail;
   logic [PICKS_W-1:0]    cfg_init_picks;

   // monitor state as predicted
   barrier_phase_type     m_phase;
   logic                  m_emitter;
   logic [15:0]           m_run_timer;
   logic [7:0]            m_ivl;
   logic [BRIGHT_W-1:0]   m_off;
   logic [2:0]            m_pick_idx;
   logic [2:0]            m_pass_cnt;
   logic [FAIL_W-1:0]     m_fails;
   logic [TOTAL_W-1:0]    m_total;
   logic [STATUS_W-1:0]   m_status;

   rsp_word_type          due_status_q[$];
   int                    error_count = 0;
   bit                    no_idle = 1'b0;

   modulated_light_barrier_monitor u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("** modulated_light_barrier_monitor: FAILED **");
      $finish;
   end

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------
   function automatic void model_reset();
      cfg_timeout    = TIMEOUT_RST;
      cfg_interval   = INTERVAL_RST;
      cfg_min_diff   = MIN_DIFF_RST;
      cfg_ratio      = RATIO_RST;
      cfg_max_fail   = MAX_FAIL_RST;
      cfg_init_picks = INIT_PKS_RST;
      m_phase        = PH_IDLE;
      m_emitter      = 1'b0;
      m_run_timer    = '0;
      m_ivl          = '0;
      m_off          = '0;
      m_pick_idx     = '0;
      m_pass_cnt     = '0;
      m_fails        = '0;
      m_total        = '0;
      m_status       = STAT_IDLE;
   endfunction

   // safe pick: dark off reading with any light, or a clear rise and ratio
   function automatic bit pick_ok(input logic [BRIGHT_W-1:0] off_lvl,
                                  input logic [BRIGHT_W-1:0] on_lvl);
      logic [31:0] on_scaled;
      logic [31:0] off_scaled;
      if (off_lvl == 0 && on_lvl != 0) return 1'b1;
      if (on_lvl <= off_lvl) return 1'b0;
      if ((on_lvl - off_lvl) < cfg_min_diff) return 1'b0;
      on_scaled  = 32'(on_lvl) * 32'd1000;
      off_scaled = 32'(off_lvl) * 32'(cfg_ratio);
      return on_scaled >= off_scaled;
   endfunction

   // start-up waiting stretch; counter saturates
   function automatic bit interval_elapsed();
      if (m_ivl != 8'hFF) m_ivl++;
      return m_ivl >= cfg_interval;
   endfunction

   function automatic rsp_word_type advance_barrier(input req_word_type w);
      rsp_word_type        r;
      logic [BRIGHT_W-1:0] lvl;
      bit                  timed_out;
      lvl = w.brightness;
      case (w.kind)
         KIND_START: begin
            m_run_timer = '0;
            m_ivl       = '0;
            m_fails     = '0;
            m_pick_idx  = '0;
            m_pass_cnt  = '0;
            if (cfg_init_picks == 0) begin
               m_phase   = PH_IDLE;
               m_emitter = 1'b0;
               m_status  = STAT_FAILED;
            end else begin
               m_off     = lvl;
               m_emitter = 1'b1;
               m_phase   = PH_INIT_ON;
               m_status  = STAT_PICKING;
            end
         end
         KIND_STOP: begin
            m_phase   = PH_IDLE;
            m_emitter = 1'b0;
            m_total   = '0;
         end
         KIND_TICK: if (m_phase != PH_IDLE) begin
            timed_out = (m_run_timer >= cfg_timeout);
            if (m_run_timer != 16'hFFFF) m_run_timer++;
            case (m_phase)
               PH_INIT_ON: if (interval_elapsed()) begin
                  if (pick_ok(m_off, lvl)) m_pass_cnt++;
                  m_pick_idx++;
                  m_emitter = 1'b0;
                  m_ivl     = '0;
                  m_phase   = PH_INIT_GAP;
               end
               PH_INIT_GAP: if (interval_elapsed()) begin
                  if (m_pick_idx >= cfg_init_picks) begin
                     m_emitter = 1'b0;
                     // strict majority over the picks done so far
                     if (2 * int'(m_pass_cnt) > int'(m_pick_idx)) begin
                        m_status = STAT_STARTED;
                        m_phase  = PH_RUN_OFF;
                        m_ivl    = 8'hFF;
                     end else begin
                        m_status = STAT_FAILED;
                        m_phase  = PH_IDLE;
                     end
                  end else begin
                     m_off     = lvl;
                     m_emitter = 1'b1;
                     m_ivl     = '0;
                     m_phase   = PH_INIT_ON;
                  end
               end
               default: begin
                  if (timed_out) begin
                     m_emitter = 1'b0;
                     m_phase   = PH_IDLE;
                  end else if (m_ivl < cfg_interval) begin
                     m_ivl++;
                  end else if (m_phase == PH_RUN_OFF) begin
                     m_off     = lvl;
                     m_emitter = 1'b1;
                     m_ivl     = '0;
                     m_phase   = PH_RUN_ON;
                  end else begin
                     m_emitter = 1'b0;
                     m_ivl     = '0;
                     m_phase   = PH_RUN_OFF;
                     if (m_total != 16'hFFFF) m_total++;
                     if (pick_ok(m_off, lvl)) m_fails = '0;
                     else if (m_fails != 8'hFF) m_fails++;
                  end
               end
            endcase
         end
         default: ;
      endcase
      r.emitter_on      = m_emitter;
      r.measuring       = (m_phase == PH_RUN_OFF || m_phase == PH_RUN_ON);
      r.start_status    = m_status;
      r.safe            = (m_fails <= cfg_max_fail);
      r.failures_in_row = m_fails;
      r.total_picks     = m_total;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------
   // mostly short pauses, now and then a long one
   function automatic int idle_len();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // receiver sample that fits the emitter state, with some outliers
   function automatic logic [BRIGHT_W-1:0] light_level();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return BRIGHT_W'($urandom_range(0, 4095));
      if (m_emitter) begin
         if (r < 25) return BRIGHT_W'($urandom_range(0, 400));
         return BRIGHT_W'($urandom_range(600, 4095));
      end
      if (r < 35) return '0;
      return BRIGHT_W'($urandom_range(0, 300));
   endfunction

   task automatic issue_command(input logic [KIND_W-1:0] kind,
                                input logic [BRIGHT_W-1:0] level);
      int           gap;
      req_word_type w;
      gap          = idle_len();
      w.kind       = kind;
      w.brightness = level;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      due_status_q.push_back(advance_barrier(w));
   endtask

   // hold the sender until every status word is back
   task automatic await_idle();
      if (req_valid) req_valid <= 1'b0;
      while (due_status_q.size() != 0) @(posedge clock);
   endtask

   // leaves csr_valid high; the caller drops it after the last write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         REG_TIMEOUT:  cfg_timeout    = val;
         REG_INTERVAL: cfg_interval   = val[INTERVAL_W-1:0];
         REG_MIN_DIFF: cfg_min_diff   = val[DIFF_W-1:0];
         REG_RATIO:    cfg_ratio      = val[RATIO_W-1:0];
         REG_MAX_FAIL: cfg_max_fail   = val[FAIL_W-1:0];
         REG_INIT_PKS: cfg_init_picks = val[PICKS_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_config(input logic [15:0] tmo, input logic [15:0] ivl,
                               input logic [15:0] diff, input logic [15:0] ratio,
                               input logic [15:0] maxf, input logic [15:0] picks);
      await_idle();
      write_reg(REG_TIMEOUT, tmo);
      write_reg(REG_INTERVAL, ivl);
      write_reg(REG_MIN_DIFF, diff);
      write_reg(REG_RATIO, ratio);
      write_reg(REG_MAX_FAIL, maxf);
      write_reg(REG_INIT_PKS, picks);
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // result side: random back-pressure and checking
   // ------------------------------------------------------------------------
   initial begin : rsp_throttle
      int hold_left;
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (no_idle || hold_left == 0) begin
            rsp_ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 99) < 25) hold_left = idle_len();
         end else begin
            rsp_ready <= 1'b0;
            hold_left--;
         end
      end
   end

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : status_checker
      rsp_word_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (due_status_q.size() == 0) begin
            $display("%0t: status word with none expected, expected none, actual %h",
                     $time, rsp_data);
            error_count++;
         end else begin
            want = due_status_q.pop_front();
            check_field("emitter_on", 16'(want.emitter_on), 16'(rsp_data.emitter_on));
            check_field("measuring", 16'(want.measuring), 16'(rsp_data.measuring));
            check_field("start_status", 16'(want.start_status),
                        16'(rsp_data.start_status));
            check_field("safe", 16'(want.safe), 16'(rsp_data.safe));
            check_field("failures_in_row", 16'(want.failures_in_row),
                        16'(rsp_data.failures_in_row));
            check_field("total_picks", want.total_picks, rsp_data.total_picks);
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   // ticks, unused kind and stop with nothing running
   task automatic test_idle_inputs();
      issue_command(KIND_TICK, 12'd0);
      issue_command(KIND_TICK, 12'hFFF);
      issue_command(KIND_UNUSED, 12'hA5A);
      issue_command(KIND_STOP, 12'd0);
   endtask

   // zero interval, one pick: start-up pass, a failed and a passed run pick,
   // then a restart that fails its check
   task automatic test_fast_pick_cycle();
      apply_config(16'hFFFF, 16'd0, 16'd0, 16'd1000, 16'd0, 16'd1);
      issue_command(KIND_START, 12'd0);
      issue_command(KIND_TICK, 12'hFFF);
      issue_command(KIND_TICK, 12'd3);
      issue_command(KIND_TICK, 12'hFFF);
      issue_command(KIND_TICK, 12'hFFF);
      issue_command(KIND_TICK, 12'd100);
      issue_command(KIND_TICK, 12'd101);
      issue_command(KIND_START, 12'hFFF);
      issue_command(KIND_TICK, 12'd0);
      issue_command(KIND_TICK, 12'd0);
   endtask

   // pick count truncated to zero by the register width; unused index ignored
   task automatic test_zero_picks();
      await_idle();
      write_reg(REG_INIT_PKS, 16'hFFF8);
      write_reg(REG_UNUSED, 16'hFFFF);
      csr_valid <= 1'b0;
      issue_command(KIND_START, 12'd7);
   endtask

   // a timeout of one tick ends the run on its first tick
   task automatic test_timeout();
      apply_config(16'd1, 16'd0, 16'd4095, 16'd4095, 16'd255, 16'd1);
      issue_command(KIND_START, 12'd0);
      issue_command(KIND_TICK, 12'd1);
      issue_command(KIND_TICK, 12'd0);
      issue_command(KIND_TICK, 12'd0);
   endtask

   // pick count lowered while the start-up check runs
   task automatic test_lower_picks();
      apply_config(16'hFFFF, 16'd1, 16'd5, 16'd1050, 16'd3, 16'd3);
      issue_command(KIND_START, 12'd10);
      issue_command(KIND_TICK, 12'd3000);
      issue_command(KIND_TICK, 12'd20);
      await_idle();
      write_reg(REG_INIT_PKS, 16'd1);
      csr_valid <= 1'b0;
      issue_command(KIND_TICK, 12'd22);
      issue_command(KIND_TICK, 12'd0);
   endtask

   // stop in the run clears the pick total, keeps status
   task automatic test_stop_running();
      apply_config(16'hFFFF, 16'd0, 16'd0, 16'd1000, 16'd1, 16'd1);
      issue_command(KIND_START, 12'd0);
      issue_command(KIND_TICK, 12'd50);
      issue_command(KIND_TICK, 12'd0);
      issue_command(KIND_TICK, 12'd7);
      issue_command(KIND_TICK, 12'd9);
      issue_command(KIND_STOP, 12'd0);
   endtask

   // well-formed start/tick traffic with a share of stray commands
   task automatic run_random_session(input int n_words, input int noise_pct);
      int r;
      for (int i = 0; i < n_words; i++) begin
         r = $urandom_range(0, 99);
         if (m_phase == PH_IDLE) begin
            if (r < 60) issue_command(KIND_START, light_level());
            else if (r < 85 || noise_pct == 0) issue_command(KIND_TICK, light_level());
            else if (r < 93)
               issue_command(KIND_STOP, BRIGHT_W'($urandom_range(0, 4095)));
            else issue_command(KIND_UNUSED, BRIGHT_W'($urandom_range(0, 4095)));
         end else if (r < noise_pct) begin
            case (r % 3)
               0: issue_command(KIND_STOP, BRIGHT_W'($urandom_range(0, 4095)));
               1: issue_command(KIND_UNUSED, BRIGHT_W'($urandom_range(0, 4095)));
               default: issue_command(KIND_START, light_level());
            endcase
         end else begin
            issue_command(KIND_TICK, light_level());
         end
      end
   endtask

   task automatic test_random_sessions();
      int tmo, ivl, diff, ratio, maxf, picks;
      for (int s = 0; s < 8; s++) begin
         case ($urandom_range(0, 3))
            0: tmo = 16'hFFFF;
            1: tmo = 1;
            2: tmo = $urandom_range(2, 80);
            default: tmo = $urandom_range(0, 65535);
         endcase
         ivl = ($urandom_range(0, 255) << 8) |
               (($urandom_range(0, 99) < 15) ? $urandom_range(4, 12) : $urandom_range(0, 3));
         case ($urandom_range(0, 3))
            0: diff = 0;
            1: diff = 4095;
            default: diff = $urandom_range(0, 150);
         endcase
         diff = diff | ($urandom_range(0, 15) << 12);
         case ($urandom_range(0, 3))
            0: ratio = 4095;
            1: ratio = $urandom_range(0, 999);
            default: ratio = $urandom_range(1000, 4000);
         endcase
         ratio = ratio | ($urandom_range(0, 15) << 12);
         case ($urandom_range(0, 3))
            0: maxf = 0;
            1: maxf = 255;
            default: maxf = $urandom_range(0, 4);
         endcase
         maxf  = maxf | ($urandom_range(0, 255) << 8);
         picks = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 7) : 0;
         picks = picks | ($urandom_range(0, 8191) << 3);
         no_idle = (s % 4 == 3);
         apply_config(16'(tmo), 16'(ivl), 16'(diff), 16'(ratio), 16'(maxf), 16'(picks));
         run_random_session($urandom_range(32, 48), 8);
      end
      no_idle = 1'b0;
   endtask

   // longest interval: one pick stretched over hundreds of ticks
   task automatic test_long_interval();
      no_idle = 1'b1;
      apply_config(16'hFFFF, 16'h00FF, 16'd5, 16'd1050, 16'd3, 16'd1);
      run_random_session(300, 0);
      no_idle = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data  <= '0;
      reset     <= 1'b1;
      model_reset();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_idle_inputs();
      test_fast_pick_cycle();
      test_zero_picks();
      test_timeout();
      test_lower_picks();
      test_stop_running();
      test_random_sessions();
      test_long_interval();

      await_idle();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("** modulated_light_barrier_monitor: PASSED **");
      end else begin
         $display("** modulated_light_barrier_monitor: FAILED **");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/mlbm_pkg.sv
rtl/modulated_light_barrier_monitor.sv
tb/tb_modulated_light_barrier_monitor.sv
